### rtl/rrts_pkg.sv
// rrts_pkg: shared types, codes and defaults for the round robin tick scheduler
// entry record carried along the cell chain, command codes, entry state codes
// no dependencies
`default_nettype none

package rrts_pkg;

    localparam int ENTRIES_DEF     = 8;
    localparam int STATE_W         = 2;
    localparam int SLEEP_W         = 16;
    localparam int SLICE_W         = 8;
    localparam int CMD_W           = 2;
    localparam int OUT_IDX_W       = 3;
    localparam int SLICE_LIMIT_RST = 16;

    localparam logic [STATE_W-1:0] ST_DEAD     = 2'd0;
    localparam logic [STATE_W-1:0] ST_RUNNABLE = 2'd1;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 2'd2;
    localparam logic [STATE_W-1:0] ST_BLOCKED  = 2'd3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SLEEP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPAWN = 2'd3;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [SLEEP_W-1:0] sleep;
        logic [SLICE_W-1:0] slice;
    } entry_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] spawned_entry;
        logic                 spawn_ok;
        logic                 switched;
        logic [OUT_IDX_W-1:0] running_entry;
    } result_t;

endpackage

`default_nettype wire

### rtl/rrts_cell.sv
// rrts_cell: one task entry of the rotating table, passed to its neighbor each cycle
// depends on rrts_pkg
`default_nettype none

module rrts_cell #(
    parameter logic [rrts_pkg::STATE_W-1:0] RESET_STATE = rrts_pkg::ST_DEAD
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire rrts_pkg::entry_t d,
    output      rrts_pkg::entry_t q
);

    rrts_pkg::entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.state <= RESET_STATE;
            entry_reg.sleep <= '0;
            entry_reg.slice <= '0;
        end else begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

### rtl/rrts_ctrl.sv
// rrts_ctrl: head unit of the cell ring, runs the tick, sleep, exit and spawn sequence
// sees the entry leaving the head cell and feeds the tail cell; depends on rrts_pkg
`default_nettype none

module rrts_ctrl #(
    parameter int ENTRIES = rrts_pkg::ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [rrts_pkg::CMD_W-1:0]    in_cmd,
    input  wire logic [rrts_pkg::SLEEP_W-1:0]  in_ticks,
    input  wire logic [rrts_pkg::SLICE_W-1:0]  slice_limit,
    input  wire rrts_pkg::entry_t              head_q,
    output      rrts_pkg::entry_t              tail_d,
    output      logic                          res_valid,
    input  wire logic                          res_ready,
    output      rrts_pkg::result_t             res
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SCAN   = 3'd1;
    localparam logic [2:0] PH_DECIDE = 3'd2;
    localparam logic [2:0] PH_COMMIT = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [2:0]                     phase_reg, phase_next;
    logic [IDX_W-1:0]               head_idx_reg, head_idx_next;
    logic [IDX_W-1:0]               cnt_reg, cnt_next;
    logic [IDX_W-1:0]               cur_reg, cur_next;
    logic [rrts_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [rrts_pkg::SLEEP_W-1:0]   ticks_reg, ticks_next;
    logic                           act_reg, act_next;
    logic                           resched_reg, resched_next;
    logic                           keep_cur_reg, keep_cur_next;
    logic                           cand_valid_reg, cand_valid_next;
    logic [IDX_W-1:0]               cand_reg, cand_next;
    logic [IDX_W:0]                 cand_dist_reg, cand_dist_next;
    logic                           dead_valid_reg, dead_valid_next;
    logic [IDX_W-1:0]               dead_idx_reg, dead_idx_next;
    logic [rrts_pkg::SLEEP_W-1:0]   cur_sleep_reg, cur_sleep_next;
    logic [rrts_pkg::SLICE_W-1:0]   cur_slice_reg, cur_slice_next;
    logic [IDX_W-1:0]               target_reg, target_next;
    logic                           switched_reg, switched_next;
    logic                           ok_reg, ok_next;

    rrts_pkg::entry_t               visit;
    logic                           is_cur;
    logic [IDX_W:0]                 gap;
    logic [IDX_W+2:0]               run_ext;
    logic [IDX_W+2:0]               claim_ext;

    always_comb begin
        head_idx_next = (head_idx_reg == LAST_IDX) ? '0 : head_idx_reg + 1'b1;
        is_cur = (head_idx_reg == cur_reg);
        gap = {1'b0, head_idx_reg} - {1'b0, cur_reg};
        if (head_idx_reg < cur_reg) begin
            gap = gap + (IDX_W + 1)'(ENTRIES);
        end

        visit           = head_q;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        cmd_next        = cmd_reg;
        ticks_next      = ticks_reg;
        act_next        = act_reg;
        resched_next    = resched_reg;
        keep_cur_next   = keep_cur_reg;
        cand_valid_next = cand_valid_reg;
        cand_next       = cand_reg;
        cand_dist_next  = cand_dist_reg;
        dead_valid_next = dead_valid_reg;
        dead_idx_next   = dead_idx_reg;
        cur_sleep_next  = cur_sleep_reg;
        cur_slice_next  = cur_slice_reg;
        target_next     = target_reg;
        switched_next   = switched_reg;
        ok_next         = ok_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                if (in_valid) begin
                    cmd_next        = in_cmd;
                    ticks_next      = in_ticks;
                    act_next        = (in_cmd == rrts_pkg::CMD_TICK)
                                   || (in_cmd == rrts_pkg::CMD_EXIT)
                                   || ((in_cmd == rrts_pkg::CMD_SLEEP) && (in_ticks != '0));
                    cnt_next        = '0;
                    resched_next    = 1'b0;
                    keep_cur_next   = 1'b0;
                    cand_valid_next = 1'b0;
                    dead_valid_next = 1'b0;
                    switched_next   = 1'b0;
                    ok_next         = 1'b0;
                    phase_next      = PH_SCAN;
                end
            end
            PH_SCAN: begin
                if ((cmd_reg == rrts_pkg::CMD_SPAWN) && (head_q.state == rrts_pkg::ST_DEAD)
                    && (!dead_valid_reg || (head_idx_reg < dead_idx_reg))) begin
                    dead_valid_next = 1'b1;
                    dead_idx_next   = head_idx_reg;
                end
                if (is_cur) begin
                    cur_sleep_next = head_q.sleep;
                    cur_slice_next = head_q.slice;
                    if (act_reg && (cmd_reg == rrts_pkg::CMD_SLEEP)) begin
                        visit.state = rrts_pkg::ST_BLOCKED;
                        visit.sleep = ticks_reg;
                    end
                    if (cmd_reg == rrts_pkg::CMD_EXIT) begin
                        visit.state = rrts_pkg::ST_DEAD;
                    end
                    if (act_reg) begin
                        if ((visit.state == rrts_pkg::ST_RUNNING)
                            && (visit.slice < slice_limit)) begin
                            visit.slice = visit.slice + 1'b1;
                        end else begin
                            resched_next = 1'b1;
                            if (visit.state == rrts_pkg::ST_RUNNING) begin
                                visit.state = rrts_pkg::ST_RUNNABLE;
                                visit.slice = '0;
                            end
                        end
                        keep_cur_next = (visit.state == rrts_pkg::ST_RUNNABLE);
                    end
                end else if (act_reg) begin
                    if (visit.state == rrts_pkg::ST_BLOCKED) begin
                        if (visit.sleep != '0) begin
                            visit.sleep = visit.sleep - 1'b1;
                        end
                        if (visit.sleep == '0) begin
                            visit.state = rrts_pkg::ST_RUNNABLE;
                        end
                    end
                    if ((head_idx_reg != '0) && (visit.state == rrts_pkg::ST_RUNNABLE)
                        && (!cand_valid_reg || (gap < cand_dist_reg))) begin
                        cand_valid_next = 1'b1;
                        cand_next       = head_idx_reg;
                        cand_dist_next  = gap;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    phase_next = PH_DECIDE;
                end
            end
            PH_DECIDE: begin
                if (act_reg && resched_reg) begin
                    if (cand_valid_reg) begin
                        target_next = cand_reg;
                    end else if (keep_cur_reg) begin
                        target_next = cur_reg;
                    end else begin
                        target_next = '0;
                    end
                    cur_next      = target_next;
                    switched_next = 1'b1;
                    phase_next    = PH_COMMIT;
                end else if ((cmd_reg == rrts_pkg::CMD_SPAWN) && dead_valid_reg) begin
                    target_next = dead_idx_reg;
                    ok_next     = 1'b1;
                    phase_next  = PH_COMMIT;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_COMMIT: begin
                if (head_idx_reg == target_reg) begin
                    if (cmd_reg == rrts_pkg::CMD_SPAWN) begin
                        visit.state = rrts_pkg::ST_RUNNABLE;
                        visit.sleep = cur_sleep_reg;
                        visit.slice = cur_slice_reg;
                    end else begin
                        visit.state = rrts_pkg::ST_RUNNING;
                        visit.slice = rrts_pkg::SLICE_W'(1);
                    end
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                if (res_ready) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        tail_d = visit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            head_idx_reg <= '0;
            cur_reg      <= '0;
        end else begin
            phase_reg    <= phase_next;
            head_idx_reg <= head_idx_next;
            cur_reg      <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        cmd_reg        <= cmd_next;
        ticks_reg      <= ticks_next;
        act_reg        <= act_next;
        resched_reg    <= resched_next;
        keep_cur_reg   <= keep_cur_next;
        cand_valid_reg <= cand_valid_next;
        cand_reg       <= cand_next;
        cand_dist_reg  <= cand_dist_next;
        dead_valid_reg <= dead_valid_next;
        dead_idx_reg   <= dead_idx_next;
        cur_sleep_reg  <= cur_sleep_next;
        cur_slice_reg  <= cur_slice_next;
        target_reg     <= target_next;
        switched_reg   <= switched_next;
        ok_reg         <= ok_next;
    end

    assign in_ready  = (phase_reg == PH_IDLE);
    assign res_valid = (phase_reg == PH_DONE);

    assign run_ext   = {3'b000, cur_reg};
    assign claim_ext = ok_reg ? {3'b000, dead_idx_reg} : '0;

    assign res.running_entry = run_ext[rrts_pkg::OUT_IDX_W-1:0];
    assign res.switched      = switched_reg;
    assign res.spawn_ok      = ok_reg;
    assign res.spawned_entry = claim_ext[rrts_pkg::OUT_IDX_W-1:0];

endmodule

`default_nettype wire

### rtl/round_robin_tick_scheduler.sv
// round_robin_tick_scheduler: top level, ring of task entry cells with a head unit
// depends on rrts_pkg, rrts_cell, rrts_ctrl
//
//   channel   handshake            payload
//   s_        s_tvalid/s_tready    s_tuser cmd, s_tdata sleep_ticks
//   m_        m_tvalid/m_tready    m_tdata running_entry, switched, spawn_ok, spawned_entry
//   cfg_      cfg_valid/cfg_ready  cfg_data slice_limit
//
// the entries rotate through the cell ring one cell per cycle; an item takes one full
// rotation to age, wake and search, then a decide step chooses; if it switches or
// spawns, it waits for the chosen entry to reach the head, then offers the result
// one item at a time; the next item is taken while a result waits in the output register
// aresetn (synchronous) loads entry 0 running, all others dead, slice_limit 16
`default_nettype none

module round_robin_tick_scheduler #(
    parameter int ENTRIES = rrts_pkg::ENTRIES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [15:0]                    s_tdata,   // sleep_ticks[15:0]
    input  wire logic [rrts_pkg::CMD_W-1:0]     s_tuser,   // cmd[1:0]
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [7:0]                     m_tdata,   // running_entry[2:0], switched[3],
                                                           // spawn_ok[4], spawned_entry[7:5]
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [rrts_pkg::SLICE_W-1:0]   cfg_data
);

    rrts_pkg::entry_t               chain_q [ENTRIES];
    rrts_pkg::entry_t               tail_d;
    rrts_pkg::result_t              res;
    logic                           res_valid;
    logic                           res_ready;
    logic [rrts_pkg::SLICE_W-1:0]   slice_limit_reg;
    logic                           m_tvalid_reg;
    logic [7:0]                     m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_limit_reg <= rrts_pkg::SLICE_W'(rrts_pkg::SLICE_LIMIT_RST);
        end else if (cfg_valid) begin
            slice_limit_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        rrts_cell #(
            .RESET_STATE((k == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_DEAD)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .d       ((k == ENTRIES - 1) ? tail_d : chain_q[(k + 1) % ENTRIES]),
            .q       (chain_q[k])
        );
    end

    rrts_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_ticks    (s_tdata),
        .slice_limit (slice_limit_reg),
        .head_q      (chain_q[0]),
        .tail_d      (tail_d),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output word register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### tb/sv/round_robin_tick_scheduler_tb.sv
// round_robin_tick_scheduler_tb: self-checking bench for the round robin tick scheduler
// drives command words with random gaps and stalls, predicts each result word in place
// depends on rrts_pkg and round_robin_tick_scheduler

module round_robin_tick_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENT     = rrts_pkg::ENTRIES_DEF;
    localparam int N_PLAN    = 26;
    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 203;
    localparam int MAX_CYC   = 600_000;

    typedef struct {
        logic [rrts_pkg::CMD_W-1:0]   cmd;
        logic [rrts_pkg::SLEEP_W-1:0] ticks;
        bit                           typed;
        rrts_pkg::result_t            res;
    } plan_row_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic [rrts_pkg::CMD_W-1:0]     s_tuser   = rrts_pkg::CMD_TICK;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rrts_pkg::SLICE_W-1:0]   cfg_data  = '0;

    // scheduler mirror
    logic [rrts_pkg::STATE_W-1:0]   ent_state [N_ENT];
    logic [rrts_pkg::SLEEP_W-1:0]   ent_sleep [N_ENT];
    logic [rrts_pkg::SLICE_W-1:0]   ent_slice [N_ENT];
    int                             cur_ent;
    logic [rrts_pkg::SLICE_W-1:0]   slice_lim;

    rrts_pkg::result_t              sched_outcomes [$];
    plan_row_t                      plan [N_PLAN];
    int                             mismatches = 0;
    int                             cycles = 0;
    int                             stall_left = 0;
    bit                             gaps_on = 1'b0;

    round_robin_tick_scheduler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("round_robin_tick_scheduler_tb: done, errors");
            $finish;
        end
    end

    // age sleepers, then keep or replace the running entry
    function automatic bit advance_tick();
        int c;
        int i;
        c = cur_ent;
        for (i = (c + 1) % N_ENT; i != c; i = (i + 1) % N_ENT) begin
            if (ent_state[i] == rrts_pkg::ST_BLOCKED) begin
                if (ent_sleep[i] != 0)
                    ent_sleep[i] = ent_sleep[i] - 1'b1;
                if (ent_sleep[i] == 0)
                    ent_state[i] = rrts_pkg::ST_RUNNABLE;
            end
        end
        if (ent_state[c] == rrts_pkg::ST_RUNNING && ent_slice[c] < slice_lim) begin
            ent_slice[c] = ent_slice[c] + 1'b1;
            return 1'b0;
        end
        if (ent_state[c] == rrts_pkg::ST_RUNNING) begin
            ent_state[c] = rrts_pkg::ST_RUNNABLE;
            ent_slice[c] = '0;
        end
        i = (c + 1) % N_ENT;
        while (i != c) begin
            if (i != 0 && ent_state[i] == rrts_pkg::ST_RUNNABLE)
                break;
            i = (i + 1) % N_ENT;
        end
        if (ent_state[i] != rrts_pkg::ST_RUNNABLE)
            i = 0;
        cur_ent = i;
        ent_state[i] = rrts_pkg::ST_RUNNING;
        ent_slice[i] = rrts_pkg::SLICE_W'(1);
        return 1'b1;
    endfunction

    function automatic rrts_pkg::result_t run_command(logic [rrts_pkg::CMD_W-1:0] cmd,
                                                      logic [rrts_pkg::SLEEP_W-1:0] ticks);
        rrts_pkg::result_t r;
        int                i;
        int                c;
        r = '0;
        c = cur_ent;
        case (cmd)
            rrts_pkg::CMD_TICK: begin
                r.switched = advance_tick();
            end
            rrts_pkg::CMD_SLEEP: begin
                if (ticks != 0) begin
                    ent_state[c] = rrts_pkg::ST_BLOCKED;
                    ent_sleep[c] = ticks;
                    r.switched = advance_tick();
                end
            end
            rrts_pkg::CMD_EXIT: begin
                ent_state[c] = rrts_pkg::ST_DEAD;
                r.switched = advance_tick();
            end
            default: begin
                for (i = 0; i < N_ENT; i++) begin
                    if (ent_state[i] == rrts_pkg::ST_DEAD)
                        break;
                end
                if (i < N_ENT) begin
                    ent_state[i] = rrts_pkg::ST_RUNNABLE;
                    ent_slice[i] = ent_slice[c];
                    ent_sleep[i] = ent_sleep[c];
                    r.spawn_ok = 1'b1;
                    r.spawned_entry = i[rrts_pkg::OUT_IDX_W-1:0];
                end
            end
        endcase
        r.running_entry = cur_ent[rrts_pkg::OUT_IDX_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t mk_row(logic [rrts_pkg::CMD_W-1:0] cmd,
                                         logic [rrts_pkg::SLEEP_W-1:0] ticks,
                                         bit typed, logic [2:0] run, bit sw, bit ok,
                                         logic [2:0] spawned);
        plan_row_t p;
        p.cmd = cmd;
        p.ticks = ticks;
        p.typed = typed;
        p.res.running_entry = run;
        p.res.switched = sw;
        p.res.spawn_ok = ok;
        p.res.spawned_entry = spawned;
        return p;
    endfunction

    task automatic pause_sender(int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_word(logic [rrts_pkg::CMD_W-1:0] cmd,
                             logic [rrts_pkg::SLEEP_W-1:0] ticks, bit typed,
                             rrts_pkg::result_t typed_res);
        rrts_pkg::result_t r;
        if (gaps_on && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 17));
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= ticks;
        do @(posedge aclk); while (!s_tready);
        r = run_command(cmd, ticks);
        sched_outcomes.push_back(typed ? typed_res : r);
    endtask

    task automatic settle_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sched_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_slice_limit(logic [rrts_pkg::SLICE_W-1:0] v);
        settle_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        slice_lim = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly short sleeps so blocked entries wake again
    task automatic send_random_word();
        int                         p;
        logic [rrts_pkg::CMD_W-1:0] cmd;
        logic [15:0]                ticks;
        p = $urandom_range(0, 99);
        ticks = 16'($urandom);
        if (p < 45) begin
            cmd = rrts_pkg::CMD_TICK;
        end else if (p < 65) begin
            cmd = rrts_pkg::CMD_SLEEP;
            case ($urandom_range(0, 9))
                0: ticks = '0;
                1: ticks = 16'($urandom);
                default: ticks = 16'($urandom_range(1, 12));
            endcase
        end else if (p < 77) begin
            cmd = rrts_pkg::CMD_EXIT;
        end else begin
            cmd = rrts_pkg::CMD_SPAWN;
        end
        send_word(cmd, ticks, 1'b0, '0);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        rrts_pkg::result_t got;
        rrts_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = rrts_pkg::result_t'(m_tdata);
            if (sched_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", m_tdata);
            end else begin
                want = sched_outcomes.pop_front();
                if (got.running_entry != want.running_entry || got.switched != want.switched
                    || got.spawn_ok != want.spawn_ok
                    || got.spawned_entry != want.spawned_entry) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
                                 want.running_entry, want.switched, want.spawn_ok,
                                 want.spawned_entry, got.running_entry, got.switched,
                                 got.spawn_ok, got.spawned_entry);
                end
            end
        end
    end

    initial begin
        logic [rrts_pkg::SLICE_W-1:0] limits [N_PHASES];
        int k;
        int ph;

        for (k = 0; k < N_ENT; k++) begin
            ent_state[k] = rrts_pkg::ST_DEAD;
            ent_sleep[k] = '0;
            ent_slice[k] = '0;
        end
        ent_state[0] = rrts_pkg::ST_RUNNING;
        cur_ent = 0;
        slice_lim = rrts_pkg::SLICE_W'(rrts_pkg::SLICE_LIMIT_RST);

        plan[0]  = mk_row(rrts_pkg::CMD_TICK,  16'h0000, 1'b1, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[1]  = mk_row(rrts_pkg::CMD_SLEEP, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b0, 3'd0);
        // lone idle entry exits and is picked again while dead
        plan[2]  = mk_row(rrts_pkg::CMD_EXIT,  16'hffff, 1'b1, 3'd0, 1'b1, 1'b0, 3'd0);
        plan[3]  = mk_row(rrts_pkg::CMD_SPAWN, 16'h0000, 1'b1, 3'd0, 1'b0, 1'b1, 3'd1);
        plan[4]  = mk_row(rrts_pkg::CMD_SPAWN, 16'hffff, 1'b1, 3'd0, 1'b0, 1'b1, 3'd2);
        plan[5]  = mk_row(rrts_pkg::CMD_SLEEP, 16'hffff, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[6]  = mk_row(rrts_pkg::CMD_TICK,  16'haaaa, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[7]  = mk_row(rrts_pkg::CMD_EXIT,  16'h5555, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[8]  = mk_row(rrts_pkg::CMD_SPAWN, 16'haaaa, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[9]  = mk_row(rrts_pkg::CMD_SPAWN, 16'h5555, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[10] = mk_row(rrts_pkg::CMD_SPAWN, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[11] = mk_row(rrts_pkg::CMD_SPAWN, 16'h0001, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[12] = mk_row(rrts_pkg::CMD_SPAWN, 16'h8000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[13] = mk_row(rrts_pkg::CMD_SPAWN, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        // table full
        plan[14] = mk_row(rrts_pkg::CMD_SPAWN, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[15] = mk_row(rrts_pkg::CMD_SLEEP, 16'h0001, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[16] = mk_row(rrts_pkg::CMD_TICK,  16'h0000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        plan[17] = mk_row(rrts_pkg::CMD_SLEEP, 16'h8000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);
        // drain the table down to the sleeping idle entry
        for (k = 18; k < N_PLAN; k++)
            plan[k] = mk_row(rrts_pkg::CMD_EXIT, 16'h0000, 1'b0, 3'd0, 1'b0, 1'b0, 3'd0);

        limits[0] = 8'd1;
        limits[1] = 8'd255;
        limits[2] = 8'd2;
        limits[3] = 8'($urandom_range(3, 40));
        limits[4] = 8'd1;
        limits[5] = 8'($urandom_range(1, 255));
        limits[6] = 8'd255;
        limits[7] = 8'($urandom_range(1, 8));

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        gaps_on = 1'b1;

        for (k = 0; k < N_PLAN; k++)
            send_word(plan[k].cmd, plan[k].ticks, plan[k].typed, plan[k].res);

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_slice_limit(limits[ph]);
            gaps_on = (ph != 2) && (ph != N_PHASES - 1);
            for (k = 0; k < PHASE_LEN; k++) begin
                if (ph == 3 && k == 100)
                    settle_results();
                send_random_word();
            end
        end

        settle_results();
        repeat (2 * N_ENT + 8) @(posedge aclk);
        if (mismatches == 0 && sched_outcomes.size() == 0)
            $display("round_robin_tick_scheduler_tb: done, clean");
        else
            $display("round_robin_tick_scheduler_tb: done, errors");
        $finish;
    end

endmodule
